// ===== design/assert_macros.svh =====
// Assertion macros shared by the blur design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SGB_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("blur assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SGB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("blur assertion failed");

`endif

// ===== design/sgb_pkg.sv =====
// Types and constants of the separable blur block.
package sgb_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_RADIUS = 4;
    localparam int TAPS       = 2 * MAX_RADIUS + 1;
    localparam int LINES      = 2 * MAX_RADIUS;
    localparam int NUM_CH     = 4;
    localparam int PIX_W      = 16;
    localparam int COEF_BITS  = 16;
    localparam int NUM_COEF   = 5;
    localparam int VSUM_W     = 24;
    localparam int COL_W      = 10;
    localparam int SLOT_W     = 3;
    localparam int DIM_W      = 11;
    localparam int K_W        = 4;
    localparam int PROD_W     = COEF_BITS + VSUM_W;
    localparam int ACC_W      = PROD_W + 4;
    localparam int VSHIFT     = COEF_BITS - 8;
    localparam int HSHIFT     = COEF_BITS + 8;
    localparam int RAM_DEPTH  = LINES * MAX_WIDTH;
    localparam int RAM_W      = NUM_CH * PIX_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_0 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_2 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_3 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_4 = 3'd7;

    typedef struct packed {
        logic [NUM_CH-1:0][PIX_W-1:0] pix;
        logic [COL_W-1:0]             col;
        logic [SLOT_W-1:0]            slot;
        logic                         do_v;
        logic                         do_h;
        logic                         row_end;
        logic                         frame_end;
    } item_t;

    typedef struct packed {
        logic [2:0]                         radius;
        logic [DIM_W-1:0]                   width;
        logic [DIM_W-1:0]                   height;
        logic [NUM_COEF-1:0][COEF_BITS-1:0] coeff;
    } cfg_t;

endpackage

// ===== design/sgb_in_if.sv =====
// Pixel request channel into the blur block.
interface sgb_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] chan_red;
    logic [15:0] chan_green;
    logic [15:0] chan_blue;
    logic [15:0] chan_alpha;

    modport source (output valid, output chan_red, output chan_green, output chan_blue,
                    output chan_alpha, input ready);
    modport sink (input valid, input chan_red, input chan_green, input chan_blue,
                  input chan_alpha, output ready);
endinterface

// ===== design/sgb_out_if.sv =====
// Blurred pixel request channel out of the blur block.
interface sgb_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_red;
    logic [15:0] out_green;
    logic [15:0] out_blue;
    logic [15:0] out_alpha;
    logic        row_end;
    logic        frame_end;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output out_alpha, output row_end, output frame_end, input ready);
    modport sink (input valid, input out_red, input out_green, input out_blue,
                  input out_alpha, input row_end, input frame_end, output ready);
endinterface

// ===== design/sgb_ram.sv =====
// Generic single write port RAM with one registered read port.
module sgb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/sgb_front.sv =====
// Front end: accepts pixels, tracks the raster position and classifies each request.
module sgb_front (
    input  logic           clk,
    input  logic           rst_n,
    input  sgb_pkg::cfg_t  cfg,
    sgb_in_if.sink         pix_in,
    input  logic           full,
    output logic           push,
    output sgb_pkg::item_t push_item
);
    import sgb_pkg::*;

    logic [COL_W-1:0] col_reg, col_next;
    logic [COL_W-1:0] row_reg, row_next;
    logic [K_W-1:0]   two_r;
    logic             last_col;
    logic             last_row;

    assign pix_in.ready = !full;
    assign push         = pix_in.valid && !full;

    assign two_r    = {1'b0, cfg.radius} << 1;
    assign last_col = (DIM_W'(col_reg) + DIM_W'(1)) >= cfg.width;
    assign last_row = (DIM_W'(row_reg) + DIM_W'(1)) >= cfg.height;

    always_comb
    begin
        push_item.pix[0]   = pix_in.chan_red;
        push_item.pix[1]   = pix_in.chan_green;
        push_item.pix[2]   = pix_in.chan_blue;
        push_item.pix[3]   = pix_in.chan_alpha;
        push_item.col      = col_reg;
        push_item.slot     = row_reg[SLOT_W-1:0];
        push_item.do_v     = row_reg >= COL_W'(two_r);
        push_item.do_h     = (row_reg >= COL_W'(two_r)) && (col_reg >= COL_W'(two_r));
        push_item.row_end  = last_col;
        push_item.frame_end = last_col && last_row;

        col_next = col_reg;
        row_next = row_reg;
        if (push)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + COL_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// ===== design/sgb_fifo.sv =====
// Two-entry queue that decouples the front end from the filter engine.
`include "assert_macros.svh"
module sgb_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sgb_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           pop_valid,
    output sgb_pkg::item_t pop_item
);
    import sgb_pkg::*;

    item_t      mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = count_reg == 2'd2;
    assign pop_valid = count_reg != 2'd0;
    assign pop_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    `SGB_ASSERT_IMP(a_no_overflow, push, count_reg != 2'd2)
    `SGB_ASSERT_IMP(a_no_underflow, pop, count_reg != 2'd0)
    `SGB_ASSERT_IMP(a_count_bound, 1'b1, count_reg != 2'd3)

endmodule

// ===== design/sgb_back.sv =====
// Filter engine: vertical and horizontal weighted sums, one tap per step.
`include "assert_macros.svh"
module sgb_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  sgb_pkg::cfg_t             cfg,
    input  logic                      item_valid,
    input  sgb_pkg::item_t            item,
    output logic                      pop,
    output logic                      ram_we,
    output logic [$clog2(sgb_pkg::RAM_DEPTH)-1:0] ram_waddr,
    output logic [sgb_pkg::RAM_W-1:0] ram_wdata,
    output logic [$clog2(sgb_pkg::RAM_DEPTH)-1:0] ram_raddr,
    input  logic [sgb_pkg::RAM_W-1:0] ram_rdata,
    sgb_out_if.source                 pix_out
);
    import sgb_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_VRD, S_VMUL, S_VFIN, S_VSAT, S_HMUL, S_HFIN, S_OUT, S_WR
    } state_t;

    state_t                                  state_reg, state_next;
    logic [K_W-1:0]                          k_reg, k_next;
    logic                                    prod_valid_reg, prod_valid_next;
    logic                                    out_valid_reg, out_valid_next;
    logic [NUM_CH-1:0][PIX_W-1:0]            out_pix_reg, out_pix_next;
    logic                                    row_end_reg, row_end_next;
    logic                                    frame_end_reg, frame_end_next;

    logic [NUM_CH-1:0][ACC_W-1:0]            acc_reg;
    logic [NUM_CH-1:0][PROD_W-1:0]           prod_reg;
    logic [NUM_CH-1:0][TAPS-1:0][VSUM_W-1:0] win_reg;
    logic [NUM_CH-1:0][TAPS-1:0][VSUM_W-1:0] work_reg;

    logic [K_W-1:0]                          two_r;
    logic [K_W-1:0]                          r4;
    logic [K_W-1:0]                          cdist;
    logic [COEF_BITS-1:0]                    coeff_sel;
    logic [SLOT_W-1:0]                       back_slot;
    logic [NUM_CH-1:0][VSUM_W-1:0]           operand;
    logic [NUM_CH-1:0][PROD_W-1:0]           prod_calc;
    logic [NUM_CH-1:0][VSUM_W-1:0]           vsum;
    logic [NUM_CH-1:0][PIX_W-1:0]            hres;
    logic                                    load_out;

    assign r4        = {1'b0, cfg.radius};
    assign two_r     = r4 << 1;
    assign cdist     = (k_reg < r4) ? (r4 - k_reg) : (k_reg - r4);
    assign coeff_sel = cfg.coeff[cdist[2:0]];
    assign back_slot = item.slot - k_reg[SLOT_W-1:0];
    assign load_out  = (state_reg == S_OUT) && (!out_valid_reg || pix_out.ready);

    assign ram_raddr = {back_slot, item.col};
    assign ram_waddr = {item.slot, item.col};
    assign ram_wdata = item.pix;
    assign ram_we    = state_reg == S_WR;
    assign pop       = state_reg == S_WR;

    always_comb
    begin
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            if (state_reg == S_HMUL)
            begin
                operand[ch] = work_reg[ch][0];
            end
            else if (k_reg == '0)
            begin
                operand[ch] = VSUM_W'(item.pix[ch]);
            end
            else
            begin
                operand[ch] = VSUM_W'(ram_rdata[ch*PIX_W +: PIX_W]);
            end
            prod_calc[ch] = coeff_sel * operand[ch];
            vsum[ch] = (|acc_reg[ch][ACC_W-1:VSHIFT+VSUM_W]) ? {VSUM_W{1'b1}}
                     : acc_reg[ch][VSHIFT+VSUM_W-1:VSHIFT];
            hres[ch] = (|acc_reg[ch][ACC_W-1:HSHIFT+PIX_W]) ? {PIX_W{1'b1}}
                     : acc_reg[ch][HSHIFT+PIX_W-1:HSHIFT];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        k_next          = k_reg;
        prod_valid_next = 1'b0;
        out_valid_next  = out_valid_reg && !pix_out.ready;
        out_pix_next    = out_pix_reg;
        row_end_next    = row_end_reg;
        frame_end_next  = frame_end_reg;
        case (state_reg)
            S_IDLE:
            begin
                k_next = '0;
                if (item_valid)
                begin
                    state_next = item.do_v ? S_VRD : S_WR;
                end
            end
            S_VRD:
            begin
                state_next = S_VMUL;
            end
            S_VMUL:
            begin
                prod_valid_next = 1'b1;
                if (k_reg == two_r)
                begin
                    state_next = S_VFIN;
                end
                else
                begin
                    k_next     = k_reg + K_W'(1);
                    state_next = S_VRD;
                end
            end
            S_VFIN:
            begin
                state_next = S_VSAT;
            end
            S_VSAT:
            begin
                k_next     = '0;
                state_next = item.do_h ? S_HMUL : S_WR;
            end
            S_HMUL:
            begin
                prod_valid_next = 1'b1;
                if (k_reg == two_r)
                begin
                    state_next = S_HFIN;
                end
                else
                begin
                    k_next = k_reg + K_W'(1);
                end
            end
            S_HFIN:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    out_pix_next   = hres;
                    row_end_next   = item.row_end;
                    frame_end_next = item.frame_end;
                    state_next     = S_WR;
                end
            end
            S_WR:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            k_reg          <= '0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_pix_reg    <= '0;
            row_end_reg    <= 1'b0;
            frame_end_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            k_reg          <= k_next;
            prod_valid_reg <= prod_valid_next;
            out_valid_reg  <= out_valid_next;
            out_pix_reg    <= out_pix_next;
            row_end_reg    <= row_end_next;
            frame_end_reg  <= frame_end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            if (state_reg == S_VMUL || state_reg == S_HMUL)
            begin
                prod_reg[ch] <= prod_calc[ch];
            end
            if (state_reg == S_IDLE || state_reg == S_VSAT)
            begin
                acc_reg[ch] <= '0;
            end
            else if (prod_valid_reg)
            begin
                acc_reg[ch] <= acc_reg[ch] + ACC_W'(prod_reg[ch]);
            end
            if (state_reg == S_VSAT)
            begin
                win_reg[ch]  <= {win_reg[ch][TAPS-2:0], vsum[ch]};
                work_reg[ch] <= {win_reg[ch][TAPS-2:0], vsum[ch]};
            end
            else if (state_reg == S_HMUL)
            begin
                work_reg[ch] <= {{VSUM_W{1'b0}}, work_reg[ch][TAPS-1:1]};
            end
        end
    end

    assign pix_out.valid     = out_valid_reg;
    assign pix_out.out_red   = out_pix_reg[0];
    assign pix_out.out_green = out_pix_reg[1];
    assign pix_out.out_blue  = out_pix_reg[2];
    assign pix_out.out_alpha = out_pix_reg[3];
    assign pix_out.row_end   = row_end_reg;
    assign pix_out.frame_end = frame_end_reg;

    `SGB_ASSERT_IMP(a_tap_bound, (state_reg == S_VMUL) || (state_reg == S_HMUL), k_reg <= two_r)
    `SGB_ASSERT_NEXT(a_result_loaded, load_out, out_valid_reg)
    `SGB_ASSERT_IMP(a_work_has_item, state_reg != S_IDLE, item_valid)

endmodule

// ===== design/separable_gaussian_blur_top.sv =====
// Top level of the separable blur: config registers, front end, queue, engine, line memory.
// An accepted item reaches an idle engine in the next cycle. A result item passes S_VRD and
// S_VMUL per column tap, S_VFIN, S_VSAT, S_HMUL per row tap, S_HFIN, S_OUT and S_WR; items
// that only add a column sum skip S_HMUL to S_OUT, and stored-only items go to S_WR. The
// single line memory read port and one shared multiplier per channel serialise the taps.
// Reset clears the counters, queue and output register and loads the register defaults.
module separable_gaussian_blur_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [sgb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sgb_pkg::CFG_DATA_W-1:0]     cfg_data,
    sgb_in_if.sink                             pix_in,
    sgb_out_if.source                          pix_out
);
    import sgb_pkg::*;

    logic [2:0]                         radius_reg;
    logic [DIM_W-1:0]                   width_reg;
    logic [DIM_W-1:0]                   height_reg;
    logic [NUM_COEF-1:0][COEF_BITS-1:0] coeff_reg;
    cfg_t                               cfg;

    logic                               full;
    logic                               push;
    item_t                              push_item;
    logic                               pop;
    logic                               pop_valid;
    item_t                              pop_item;
    logic                               ram_we;
    logic [$clog2(RAM_DEPTH)-1:0]       ram_waddr;
    logic [$clog2(RAM_DEPTH)-1:0]       ram_raddr;
    logic [RAM_W-1:0]                   ram_wdata;
    logic [RAM_W-1:0]                   ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= '0;
            width_reg  <= DIM_W'(MAX_WIDTH);
            height_reg <= DIM_W'(1024);
            coeff_reg  <= {{((NUM_COEF-1)*COEF_BITS){1'b0}}, {COEF_BITS{1'b1}}};
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RADIUS:  radius_reg   <= cfg_data[2:0];
                REG_WIDTH:   width_reg    <= cfg_data[DIM_W-1:0];
                REG_HEIGHT:  height_reg   <= cfg_data[DIM_W-1:0];
                REG_COEFF_0: coeff_reg[0] <= cfg_data;
                REG_COEFF_1: coeff_reg[1] <= cfg_data;
                REG_COEFF_2: coeff_reg[2] <= cfg_data;
                REG_COEFF_3: coeff_reg[3] <= cfg_data;
                REG_COEFF_4: coeff_reg[4] <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        cfg.radius = (radius_reg > 3'(MAX_RADIUS)) ? 3'(MAX_RADIUS) : radius_reg;
        if (width_reg == '0)
        begin
            cfg.width = DIM_W'(1);
        end
        else
        begin
            cfg.width = (width_reg > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_reg;
        end
        if (height_reg == '0)
        begin
            cfg.height = DIM_W'(1);
        end
        else
        begin
            cfg.height = (height_reg > DIM_W'(1024)) ? DIM_W'(1024) : height_reg;
        end
        cfg.coeff = coeff_reg;
    end

    sgb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pix_in    (pix_in),
        .full      (full),
        .push      (push),
        .push_item (push_item)
    );

    sgb_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_item  (pop_item)
    );

    sgb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (pop_valid),
        .item       (pop_item),
        .pop        (pop),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .pix_out    (pix_out)
    );

    sgb_ram #(
        .WIDTH (RAM_W),
        .DEPTH (RAM_DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule
